/* sv/wsp_pkg.sv */
// Shared types and constants for the WAV stream PCM decoder.
`default_nettype none

package wsp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NO_RIFF  = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE = 3'd1;
    localparam logic [2:0] ERR_BAD_FMT  = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM  = 3'd3;
    localparam logic [2:0] ERR_BAD_CHAN = 3'd4;
    localparam logic [2:0] ERR_BAD_BITS = 3'd5;
    localparam logic [2:0] ERR_NO_DATA  = 3'd6;

    // Chunk identifiers as they arrive, first byte in the top lane.
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [7:0] U8_BIAS = 8'h80;

    // Command queue between the parser and the output stage.
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCOUNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [31:0]        rate;
        logic               src_stereo;
        logic               src_16bit;
        logic [2:0]         err;
        logic               last;
    } t_wsp_cmd;

endpackage

`default_nettype wire

/* sv/wsp_front.sv */
// Byte parser: walks the RIFF chunk structure and turns samples into frame commands.
`default_nettype none

module wsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_final_byte,
    input  logic              i_q_not_full,
    output logic              o_push,
    output wsp_pkg::t_wsp_cmd o_cmd
);
    import wsp_pkg::*;

    localparam logic [3:0] PH_RIFF_HDR  = 4'd0;
    localparam logic [3:0] PH_RIFF_SKIP = 4'd1;
    localparam logic [3:0] PH_WAVE      = 4'd2;
    localparam logic [3:0] PH_FMT_HDR   = 4'd3;
    localparam logic [3:0] PH_FMT_SKIP  = 4'd4;
    localparam logic [3:0] PH_FMT_BODY  = 4'd5;
    localparam logic [3:0] PH_FMT_REST  = 4'd6;
    localparam logic [3:0] PH_DATA_HDR  = 4'd7;
    localparam logic [3:0] PH_DATA_SKIP = 4'd8;
    localparam logic [3:0] PH_SAMPLES   = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;
    localparam logic [3:0] PH_FAILED    = 4'd11;

    logic [3:0]  r_phase, n_phase, cur_phase;
    logic [3:0]  r_fbc, n_fbc, cur_fbc;
    logic [31:0] r_id, n_id, cur_id;
    logic [31:0] r_len, n_len, cur_len;
    logic [31:0] r_skip, n_skip, cur_skip;
    logic [15:0] r_tag, n_tag, cur_tag;
    logic [15:0] r_chan, n_chan, cur_chan;
    logic [15:0] r_bits, n_bits, cur_bits;
    logic [31:0] r_rate, n_rate, cur_rate;
    logic [31:0] r_dleft, n_dleft, cur_dleft;
    logic [7:0]  r_low, n_low, cur_low;
    logic [15:0] r_lefth, n_lefth, cur_lefth;
    logic        r_lane, n_lane, cur_lane;

    logic        accept;
    logic        emit;
    t_wsp_cmd    cmd;

    logic [31:0] hdr_id, hdr_len, len_base, byte_lane;
    logic        hdr_done;
    logic [3:0]  hdr_fbc;
    logic [31:0] skip_dec;

    assign accept  = i_valid && i_q_not_full;
    assign o_ready = i_q_not_full;
    assign o_push  = accept && emit;
    assign o_cmd   = cmd;

    // A first byte restarts the parse from the cleared state before it is taken.
    assign cur_phase = i_first_byte ? PH_RIFF_HDR : r_phase;
    assign cur_fbc   = i_first_byte ? '0 : r_fbc;
    assign cur_id    = i_first_byte ? '0 : r_id;
    assign cur_len   = i_first_byte ? '0 : r_len;
    assign cur_skip  = i_first_byte ? '0 : r_skip;
    assign cur_tag   = i_first_byte ? '0 : r_tag;
    assign cur_chan  = i_first_byte ? '0 : r_chan;
    assign cur_bits  = i_first_byte ? '0 : r_bits;
    assign cur_rate  = i_first_byte ? '0 : r_rate;
    assign cur_dleft = i_first_byte ? '0 : r_dleft;
    assign cur_low   = i_first_byte ? '0 : r_low;
    assign cur_lefth = i_first_byte ? '0 : r_lefth;
    assign cur_lane  = i_first_byte ? 1'b0 : r_lane;

    // Chunk header assembly: four id bytes, then a little-endian size.
    always_comb begin
        len_base = (cur_fbc == 4'd0) ? 32'd0 : cur_len;
        case (cur_fbc[1:0])
            2'd0:    byte_lane = {24'd0, i_data_byte};
            2'd1:    byte_lane = {16'd0, i_data_byte, 8'd0};
            2'd2:    byte_lane = {8'd0, i_data_byte, 16'd0};
            default: byte_lane = {i_data_byte, 24'd0};
        endcase
        hdr_id   = (cur_fbc < 4'd4) ? {cur_id[23:0], i_data_byte} : cur_id;
        hdr_len  = (cur_fbc >= 4'd4) ? (len_base | byte_lane) : len_base;
        hdr_done = (cur_fbc >= 4'd7);
        hdr_fbc  = hdr_done ? 4'd0 : cur_fbc + 4'd1;
        skip_dec = cur_skip - 32'd1;
    end

    always_comb begin
        logic [15:0] smp;
        logic        smp_ready;
        logic        smp_end;
        logic [15:0] bits_new;

        smp       = '0;
        smp_ready = 1'b0;
        smp_end   = 1'b0;
        bits_new  = {i_data_byte, cur_bits[7:0]};

        n_phase = cur_phase;
        n_fbc   = cur_fbc;
        n_id    = cur_id;
        n_len   = cur_len;
        n_skip  = cur_skip;
        n_tag   = cur_tag;
        n_chan  = cur_chan;
        n_bits  = cur_bits;
        n_rate  = cur_rate;
        n_dleft = cur_dleft;
        n_low   = cur_low;
        n_lefth = cur_lefth;
        n_lane  = cur_lane;
        emit    = 1'b0;
        cmd     = '0;

        case (cur_phase)
            PH_RIFF_HDR, PH_FMT_HDR, PH_DATA_HDR: begin
                n_id  = hdr_id;
                n_len = hdr_len;
                n_fbc = hdr_fbc;
                if (hdr_done) begin
                    if (cur_phase == PH_RIFF_HDR && hdr_id == ID_RIFF) begin
                        if (hdr_len == 32'd0) begin
                            emit     = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.err  = ERR_NO_RIFF;
                            n_phase  = PH_FAILED;
                        end else begin
                            n_phase = PH_WAVE;
                        end
                    end else if (cur_phase == PH_FMT_HDR && hdr_id == ID_FMT) begin
                        if (hdr_len < 32'd16) begin
                            emit     = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.err  = ERR_BAD_FMT;
                            n_phase  = PH_FAILED;
                        end else begin
                            n_phase = PH_FMT_BODY;
                        end
                    end else if (cur_phase == PH_DATA_HDR && hdr_id == ID_DATA) begin
                        emit = 1'b1;
                        if (hdr_len == 32'd0) begin
                            cmd.kind = KIND_ERROR;
                            cmd.err  = ERR_NO_DATA;
                            n_phase  = PH_FAILED;
                        end else begin
                            n_dleft        = hdr_len;
                            n_fbc          = 4'd0;
                            n_lane         = 1'b0;
                            n_phase        = PH_SAMPLES;
                            cmd.kind       = KIND_FORMAT;
                            cmd.rate       = cur_rate;
                            cmd.src_stereo = (cur_chan == 16'd2);
                            cmd.src_16bit  = (cur_bits == 16'd16);
                        end
                    end else if (hdr_len != 32'd0) begin
                        // Unknown chunk: skip its body, then look for the next header.
                        n_skip  = hdr_len;
                        n_phase = cur_phase + 4'd1;
                    end
                end
            end
            PH_RIFF_SKIP, PH_FMT_SKIP, PH_DATA_SKIP, PH_FMT_REST: begin
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    n_phase = (cur_phase == PH_FMT_REST) ? PH_DATA_HDR : cur_phase - 4'd1;
                end
            end
            PH_WAVE: begin
                n_id = {cur_id[23:0], i_data_byte};
                if (cur_fbc >= 4'd3) begin
                    n_fbc = 4'd0;
                    if ({cur_id[23:0], i_data_byte} != ID_WAVE) begin
                        emit     = 1'b1;
                        cmd.kind = KIND_ERROR;
                        cmd.err  = ERR_NOT_WAVE;
                        n_phase  = PH_FAILED;
                    end else begin
                        n_phase = PH_FMT_HDR;
                    end
                end else begin
                    n_fbc = cur_fbc + 4'd1;
                end
            end
            PH_FMT_BODY: begin
                case (cur_fbc)
                    4'd0:    n_tag = {8'd0, i_data_byte};
                    4'd1:    n_tag = {i_data_byte, cur_tag[7:0]};
                    4'd2:    n_chan = {8'd0, i_data_byte};
                    4'd3:    n_chan = {i_data_byte, cur_chan[7:0]};
                    4'd4:    n_rate = {24'd0, i_data_byte};
                    4'd5:    n_rate = {cur_rate[31:16], i_data_byte, cur_rate[7:0]};
                    4'd6:    n_rate = {cur_rate[31:24], i_data_byte, cur_rate[15:0]};
                    4'd7:    n_rate = {i_data_byte, cur_rate[23:0]};
                    4'd14:   n_bits = {8'd0, i_data_byte};
                    4'd15:   n_bits = bits_new;
                    default: n_bits = cur_bits;
                endcase
                if (cur_fbc == 4'd15) begin
                    n_fbc = 4'd0;
                    if (cur_tag != 16'd1) begin
                        emit     = 1'b1;
                        cmd.kind = KIND_ERROR;
                        cmd.err  = ERR_NOT_PCM;
                        n_phase  = PH_FAILED;
                    end else if (cur_chan != 16'd1 && cur_chan != 16'd2) begin
                        emit     = 1'b1;
                        cmd.kind = KIND_ERROR;
                        cmd.err  = ERR_BAD_CHAN;
                        n_phase  = PH_FAILED;
                    end else if (bits_new != 16'd8 && bits_new != 16'd16) begin
                        emit     = 1'b1;
                        cmd.kind = KIND_ERROR;
                        cmd.err  = ERR_BAD_BITS;
                        n_phase  = PH_FAILED;
                    end else if (cur_len == 32'd16) begin
                        n_phase = PH_DATA_HDR;
                    end else begin
                        n_skip  = cur_len - 32'd16;
                        n_phase = PH_FMT_REST;
                    end
                end else begin
                    n_fbc = cur_fbc + 4'd1;
                end
            end
            PH_SAMPLES: begin
                n_dleft = cur_dleft - 32'd1;
                smp_end = (n_dleft == 32'd0) || i_final_byte;
                if (cur_bits == 16'd16) begin
                    if (cur_fbc == 4'd0) begin
                        n_low = i_data_byte;
                        n_fbc = 4'd1;
                    end else begin
                        smp       = {i_data_byte, cur_low};
                        n_fbc     = 4'd0;
                        smp_ready = 1'b1;
                    end
                end else begin
                    smp       = {i_data_byte ^ U8_BIAS, 8'd0};
                    smp_ready = 1'b1;
                end
                if (smp_end) begin
                    n_phase = PH_DONE;
                end
                if (smp_ready) begin
                    if (cur_chan == 16'd2 && !cur_lane) begin
                        n_lefth = smp;
                        n_lane  = 1'b1;
                    end else begin
                        n_lane     = 1'b0;
                        emit       = 1'b1;
                        cmd.kind   = KIND_FRAME;
                        cmd.left   = (cur_chan == 16'd2) ? cur_lefth : smp;
                        cmd.right  = smp;
                        cmd.last   = smp_end;
                    end
                end
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase

        // A file that ends before the data chunk starts is reported by phase.
        if (i_final_byte) begin
            if (!emit && n_phase <= PH_DATA_SKIP) begin
                emit     = 1'b1;
                cmd      = '0;
                cmd.kind = KIND_ERROR;
                if (n_phase <= PH_RIFF_SKIP) begin
                    cmd.err = ERR_NO_RIFF;
                end else if (n_phase == PH_WAVE) begin
                    cmd.err = ERR_NOT_WAVE;
                end else if (n_phase <= PH_FMT_BODY) begin
                    cmd.err = ERR_BAD_FMT;
                end else begin
                    cmd.err = ERR_NO_DATA;
                end
                n_phase = PH_FAILED;
            end else if (n_phase == PH_SAMPLES) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF_HDR;
            r_fbc   <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_skip  <= '0;
            r_tag   <= '0;
            r_chan  <= '0;
            r_bits  <= '0;
            r_rate  <= '0;
            r_dleft <= '0;
            r_low   <= '0;
            r_lefth <= '0;
            r_lane  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_fbc   <= n_fbc;
            r_id    <= n_id;
            r_len   <= n_len;
            r_skip  <= n_skip;
            r_tag   <= n_tag;
            r_chan  <= n_chan;
            r_bits  <= n_bits;
            r_rate  <= n_rate;
            r_dleft <= n_dleft;
            r_low   <= n_low;
            r_lefth <= n_lefth;
            r_lane  <= n_lane;
        end
    end

endmodule

`default_nettype wire

/* sv/wsp_queue.sv */
// Short register queue of result commands between the parser and the output stage.
`default_nettype none

module wsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsp_pkg::t_wsp_cmd i_cmd,
    input  logic              i_pop,
    output logic              o_not_full,
    output logic              o_not_empty,
    output wsp_pkg::t_wsp_cmd o_head
);
    import wsp_pkg::*;

    t_wsp_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]     r_wptr, n_wptr;
    logic [QPTR_W-1:0]     r_rptr, n_rptr;
    logic [QCOUNT_W-1:0]   r_count, n_count;
    logic                  do_push, do_pop;

    assign o_not_full  = (r_count != QCOUNT_W'(Q_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rptr];

    assign do_push = i_push && o_not_full;
    assign do_pop  = i_pop && o_not_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/wsp_back.sv */
// Output stage: channel mixing by the output mode and the result register.
`default_nettype none

module wsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_q_not_empty,
    input  wsp_pkg::t_wsp_cmd i_q_head,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output wsp_pkg::t_wsp_cmd o_res
);
    import wsp_pkg::*;

    logic        r_stereo;
    logic        r_valid, n_valid;
    t_wsp_cmd    r_res, n_res;
    logic [16:0] mix_sum;

    // Mono output takes the floor of the channel average.
    assign mix_sum = {i_q_head.left[15], i_q_head.left} + {i_q_head.right[15], i_q_head.right};

    assign o_q_pop = i_q_not_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_res = i_q_head;
        if (i_q_head.kind == KIND_FRAME && !r_stereo) begin
            n_res.left  = mix_sum[16:1];
            n_res.right = mix_sum[16:1];
        end
        if (o_q_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stereo <= i_cfg_wr_data;
            end
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

/* sv/wav_stream_pcm_decoder.sv */
// Top level of the WAV stream PCM decoder: parser, command queue and output stage.
`default_nettype none

// Channel   Handshake                   Word
// input     i_in_valid / o_in_ready     i_data_byte, i_first_byte, i_final_byte
// output    o_out_valid / i_out_ready   o_result_kind .. o_last
// config    i_cfg_wr_en                 i_cfg_wr_data (output_stereo)
//
// One byte is taken per cycle while the queue has room; the parser classifies it in that cycle
// and any result it makes goes through the command queue and then the output result register.
// The input stalls only while the two-entry command queue is full.
// Reset is synchronous and active low; it starts the RIFF search and selects stereo output.

module wav_stream_pcm_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_final_byte,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_result_kind,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic [31:0]        o_sample_rate,
    output logic               o_source_is_stereo,
    output logic               o_source_is_16bit,
    output logic [2:0]         o_error_code,
    output logic               o_last
);
    import wsp_pkg::*;

    logic     q_not_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;
    t_wsp_cmd push_cmd;
    t_wsp_cmd head_cmd;
    t_wsp_cmd res;

    wsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_final_byte (i_final_byte),
        .i_q_not_full (q_not_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    wsp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .i_pop       (pop),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_head      (head_cmd)
    );

    wsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_not_empty (q_not_empty),
        .i_q_head      (head_cmd),
        .o_q_pop       (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_res         (res)
    );

    assign o_result_kind      = res.kind;
    assign o_left_sample      = res.left;
    assign o_right_sample     = res.right;
    assign o_sample_rate      = res.rate;
    assign o_source_is_stereo = res.src_stereo;
    assign o_source_is_16bit  = res.src_16bit;
    assign o_error_code       = res.err;
    assign o_last             = res.last;

endmodule

`default_nettype wire

/* dv/wav_stream_pcm_decoder_checker.sv */
`timescale 1ns / 100ps
// Checker for the WAV stream PCM decoder: tracks the parse of every accepted word and compares results.

module wav_stream_pcm_decoder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic               i_final_byte,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_result_kind,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    input  logic [31:0]        i_sample_rate,
    input  logic               i_source_is_stereo,
    input  logic               i_source_is_16bit,
    input  logic [2:0]         i_error_code,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending_count
);
    import wsp_pkg::*;

    typedef enum logic [3:0] {
        PH_SEEK_RIFF      = 4'd0,
        PH_SKIP_RIFF_SCAN = 4'd1,
        PH_FORM_TYPE      = 4'd2,
        PH_SEEK_FMT       = 4'd3,
        PH_SKIP_FMT_SCAN  = 4'd4,
        PH_FMT_FIELDS     = 4'd5,
        PH_FMT_TAIL       = 4'd6,
        PH_SEEK_DATA      = 4'd7,
        PH_SKIP_DATA_SCAN = 4'd8,
        PH_SAMPLES        = 4'd9,
        PH_FINISHED       = 4'd10,
        PH_ABORTED        = 4'd11
    } t_parse_phase;

    t_parse_phase phase;
    logic [3:0]   hdr_count;
    logic [31:0]  id_shift;
    logic [31:0]  chunk_len;
    logic [31:0]  skip_count;
    logic [15:0]  fmt_tag;
    logic [15:0]  chan_count;
    logic [15:0]  sample_bits;
    logic [31:0]  rate_word;
    logic [31:0]  data_count;
    logic [7:0]   low_byte;
    logic [15:0]  left_keep;
    bit           lane_busy;
    bit           out_stereo;

    t_wsp_cmd expected_results[$];
    int       fail_total = 0;

    assign o_fail_count = fail_total;

    task clear_parse();
        phase       = PH_SEEK_RIFF;
        hdr_count   = '0;
        id_shift    = '0;
        chunk_len   = '0;
        skip_count  = '0;
        fmt_tag     = '0;
        chan_count  = '0;
        sample_bits = '0;
        rate_word   = '0;
        data_count  = '0;
        low_byte    = '0;
        left_keep   = '0;
        lane_busy   = 1'b0;
    endtask

    task abort_parse(input logic [2:0] code, output bit made, output t_wsp_cmd res);
        phase    = PH_ABORTED;
        res      = '0;
        res.kind = KIND_ERROR;
        res.err  = code;
        made     = 1'b1;
    endtask

    // Chunk header: four id bytes, then the size in little-endian order.
    task take_header_byte(input logic [7:0] b, output bit complete);
        if (hdr_count == 0) chunk_len = '0;
        if (hdr_count < 4) begin
            id_shift = {id_shift[23:0], b};
        end else begin
            chunk_len = chunk_len | ({24'h0, b} << (8 * (hdr_count - 4)));
        end
        hdr_count = hdr_count + 1'b1;
        complete  = (hdr_count >= 8);
        if (complete) hdr_count = '0;
    endtask

    task start_skip(input logic [31:0] len, input t_parse_phase skip_ph,
                    input t_parse_phase hdr_ph);
        if (len == 0) begin
            phase = hdr_ph;
        end else begin
            skip_count = len;
            phase      = skip_ph;
        end
    endtask

    task take_sample(input logic [7:0] b, input logic fin, output bit made,
                     output t_wsp_cmd res);
        logic [15:0]        smp;
        logic signed [16:0] total;
        bit                 have_smp;
        bit                 ends;
        made       = 1'b0;
        res        = '0;
        smp        = '0;
        have_smp   = 1'b0;
        data_count = data_count - 1;
        ends       = (data_count == 0) || fin;
        if (sample_bits == 16) begin
            if (hdr_count == 0) begin
                low_byte  = b;
                hdr_count = 4'd1;
            end else begin
                smp       = {b, low_byte};
                hdr_count = '0;
                have_smp  = 1'b1;
            end
        end else begin
            smp      = {b ^ U8_BIAS, 8'h00};
            have_smp = 1'b1;
        end
        if (ends) phase = PH_FINISHED;
        if (have_smp) begin
            if (chan_count == 2 && !lane_busy) begin
                left_keep = smp;
                lane_busy = 1'b1;
            end else begin
                res.kind  = KIND_FRAME;
                res.left  = (chan_count == 2) ? left_keep : smp;
                res.right = smp;
                lane_busy = 1'b0;
                if (!out_stereo) begin
                    // The arithmetic shift of the sum rounds toward minus infinity.
                    total     = res.left + res.right;
                    res.left  = total[16:1];
                    res.right = total[16:1];
                end
                res.last = ends;
                made     = 1'b1;
            end
        end
    endtask

    task decode_byte(input logic [7:0] b, input logic first, input logic fin,
                     output bit made, output t_wsp_cmd res);
        bit         hdr_done;
        logic [3:0] k;
        logic [2:0] code;
        made = 1'b0;
        res  = '0;
        if (first) clear_parse();
        case (phase)
            PH_SEEK_RIFF: begin
                take_header_byte(b, hdr_done);
                if (hdr_done) begin
                    if (id_shift == ID_RIFF) begin
                        if (chunk_len == 0) abort_parse(ERR_NO_RIFF, made, res);
                        else phase = PH_FORM_TYPE;
                    end else begin
                        start_skip(chunk_len, PH_SKIP_RIFF_SCAN, PH_SEEK_RIFF);
                    end
                end
            end
            PH_SKIP_RIFF_SCAN, PH_SKIP_FMT_SCAN, PH_SKIP_DATA_SCAN: begin
                skip_count = skip_count - 1;
                // Each skip phase sits right after the header search it returns to.
                if (skip_count == 0) phase = t_parse_phase'(phase - 4'd1);
            end
            PH_FORM_TYPE: begin
                id_shift  = {id_shift[23:0], b};
                hdr_count = hdr_count + 1'b1;
                if (hdr_count >= 4) begin
                    hdr_count = '0;
                    if (id_shift != ID_WAVE) abort_parse(ERR_NOT_WAVE, made, res);
                    else phase = PH_SEEK_FMT;
                end
            end
            PH_SEEK_FMT: begin
                take_header_byte(b, hdr_done);
                if (hdr_done) begin
                    if (id_shift == ID_FMT) begin
                        if (chunk_len < 16) abort_parse(ERR_BAD_FMT, made, res);
                        else phase = PH_FMT_FIELDS;
                    end else begin
                        start_skip(chunk_len, PH_SKIP_FMT_SCAN, PH_SEEK_FMT);
                    end
                end
            end
            PH_FMT_FIELDS: begin
                k = hdr_count;
                case (k)
                    4'd0:  fmt_tag = {8'h00, b};
                    4'd1:  fmt_tag[15:8] = b;
                    4'd2:  chan_count = {8'h00, b};
                    4'd3:  chan_count[15:8] = b;
                    4'd4:  rate_word = {24'h0, b};
                    4'd5:  rate_word[15:8] = b;
                    4'd6:  rate_word[23:16] = b;
                    4'd7:  rate_word[31:24] = b;
                    4'd14: sample_bits = {8'h00, b};
                    4'd15: sample_bits[15:8] = b;
                    default: ;
                endcase
                if (k == 4'd15) begin
                    hdr_count = '0;
                    if (fmt_tag != 1) begin
                        abort_parse(ERR_NOT_PCM, made, res);
                    end else if (chan_count != 1 && chan_count != 2) begin
                        abort_parse(ERR_BAD_CHAN, made, res);
                    end else if (sample_bits != 8 && sample_bits != 16) begin
                        abort_parse(ERR_BAD_BITS, made, res);
                    end else begin
                        start_skip(chunk_len - 32'd16, PH_FMT_TAIL, PH_SEEK_DATA);
                    end
                end else begin
                    hdr_count = k + 1'b1;
                end
            end
            PH_FMT_TAIL: begin
                skip_count = skip_count - 1;
                if (skip_count == 0) phase = PH_SEEK_DATA;
            end
            PH_SEEK_DATA: begin
                take_header_byte(b, hdr_done);
                if (hdr_done) begin
                    if (id_shift == ID_DATA) begin
                        if (chunk_len == 0) begin
                            abort_parse(ERR_NO_DATA, made, res);
                        end else begin
                            data_count     = chunk_len;
                            hdr_count      = '0;
                            lane_busy      = 1'b0;
                            phase          = PH_SAMPLES;
                            res.kind       = KIND_FORMAT;
                            res.rate       = rate_word;
                            res.src_stereo = (chan_count == 2);
                            res.src_16bit  = (sample_bits == 16);
                            made           = 1'b1;
                        end
                    end else begin
                        start_skip(chunk_len, PH_SKIP_DATA_SCAN, PH_SEEK_DATA);
                    end
                end
            end
            PH_SAMPLES: take_sample(b, fin, made, res);
            default: ;
        endcase
        // A file that ends before its data chunk starts gets an error by phase.
        if (fin) begin
            if (!made && phase <= PH_SKIP_DATA_SCAN) begin
                if (phase <= PH_SKIP_RIFF_SCAN) code = ERR_NO_RIFF;
                else if (phase == PH_FORM_TYPE) code = ERR_NOT_WAVE;
                else if (phase <= PH_FMT_FIELDS) code = ERR_BAD_FMT;
                else code = ERR_NO_DATA;
                abort_parse(code, made, res);
            end else if (phase == PH_SAMPLES) begin
                phase = PH_FINISHED;
            end
        end
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    task compare_result(input t_wsp_cmd want, input t_wsp_cmd got);
        int bad;
        bad = 0;
        bad += field_differs("result_kind", want.kind, got.kind);
        bad += field_differs("left_sample", want.left, got.left);
        bad += field_differs("right_sample", want.right, got.right);
        bad += field_differs("sample_rate", want.rate, got.rate);
        bad += field_differs("source_is_stereo", want.src_stereo, got.src_stereo);
        bad += field_differs("source_is_16bit", want.src_16bit, got.src_16bit);
        bad += field_differs("error_code", want.err, got.err);
        bad += field_differs("last", want.last, got.last);
        if (bad != 0) fail_total++;
    endtask

    // Results are checked before the input word of the same edge is decoded, since a
    // word can never produce its result in the cycle it is taken.
    always @(posedge i_clk) begin : watch_channels
        t_wsp_cmd got;
        t_wsp_cmd want;
        bit       made;
        if (!i_rst_n) begin
            clear_parse();
            out_stereo = 1'b1;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.kind       = i_result_kind;
                got.left       = i_left_sample;
                got.right      = i_right_sample;
                got.rate       = i_sample_rate;
                got.src_stereo = i_source_is_stereo;
                got.src_16bit  = i_source_is_16bit;
                got.err        = i_error_code;
                got.last       = i_last;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual kind %0d",
                             $time, i_result_kind);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    compare_result(want, got);
                end
            end
            if (i_cfg_wr_en) out_stereo = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_data_byte, i_first_byte, i_final_byte, made, want);
                if (made) expected_results.push_back(want);
            end
        end
        o_pending_count <= expected_results.size();
    end

endmodule

/* dv/wav_stream_pcm_decoder_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the WAV stream PCM decoder: builds WAV byte streams and gives the verdict.

module wav_stream_pcm_decoder_tb;
    import wsp_pkg::*;

    localparam int ITEM_TARGET   = 1850;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 120;

    typedef enum int {
        FILE_GOOD,
        FILE_NO_RIFF,
        FILE_RIFF_EMPTY,
        FILE_NOT_WAVE,
        FILE_FMT_SHORT,
        FILE_NOT_PCM,
        FILE_BAD_CHAN,
        FILE_BAD_BITS,
        FILE_DATA_EMPTY,
        FILE_TRUNCATED,
        FILE_NOISE
    } t_file_kind;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = 8'h00;
    logic               first_byte = 1'b0;
    logic               final_byte = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         result_kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        sample_rate;
    logic               source_is_stereo;
    logic               source_is_16bit;
    logic [2:0]         error_code;
    logic               frame_last;

    int         fail_count;
    int         pending_count;
    int         bytes_sent = 0;
    int         hold_requests = 0;
    int         holds_started = 0;
    bit         full_rate = 1'b0;
    logic [7:0] wav_bytes[$];

    wav_stream_pcm_decoder u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_first_byte       (first_byte),
        .i_final_byte       (final_byte),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_result_kind      (result_kind),
        .o_left_sample      (left_sample),
        .o_right_sample     (right_sample),
        .o_sample_rate      (sample_rate),
        .o_source_is_stereo (source_is_stereo),
        .o_source_is_16bit  (source_is_16bit),
        .o_error_code       (error_code),
        .o_last             (frame_last)
    );

    wav_stream_pcm_decoder_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_first_byte       (first_byte),
        .i_final_byte       (final_byte),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_result_kind      (result_kind),
        .i_left_sample      (left_sample),
        .i_right_sample     (right_sample),
        .i_sample_rate      (sample_rate),
        .i_source_is_stereo (source_is_stereo),
        .i_source_is_16bit  (source_is_16bit),
        .i_error_code       (error_code),
        .i_last             (frame_last),
        .o_fail_count       (fail_count),
        .o_pending_count    (pending_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
        end
        $display("%0t: no word moved for %0d cycles, %0d results still expected",
                 $time, STALL_LIMIT, pending_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: short and long stalls, long ready stretches, and the requested hold-off.
    initial begin : receiver
        int r;
        int run;
        forever begin
            if (holds_started != hold_requests) begin
                holds_started = hold_requests;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_ready <= 1'b1;
                    run = $urandom_range(1, 20);
                end else if (r < 65) begin
                    out_ready <= 1'b1;
                    run = $urandom_range(50, 150);
                end else if (r < 95) begin
                    out_ready <= 1'b0;
                    run = $urandom_range(1, 4);
                end else begin
                    out_ready <= 1'b0;
                    run = $urandom_range(15, 60);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (full_rate) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Valid stays high after a word is taken; the next word or an idle gap replaces it.
    task send_word(input logic [7:0] b, input logic first, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= first;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task send_file(input bit mark_first, input bit mark_final, input bit scatter_flags);
        logic first;
        logic fin;
        for (int i = 0; i < wav_bytes.size(); i++) begin
            if (scatter_flags) begin
                first = ($urandom_range(0, 7) == 0);
                fin   = ($urandom_range(0, 7) == 0);
            end else begin
                first = mark_first && (i == 0);
                fin   = mark_final && (i == wav_bytes.size() - 1);
            end
            send_word(wav_bytes[i], first, fin);
        end
    endtask

    task drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_output_mode(input logic stereo);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= stereo;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
    endtask

    task push_id(input logic [31:0] id);
        for (int i = 3; i >= 0; i--) wav_bytes.push_back(id[8*i +: 8]);
    endtask

    task push_junk_chunk();
        logic [31:0] id;
        int          len;
        id  = $urandom;
        if (id == ID_RIFF || id == ID_WAVE || id == ID_FMT || id == ID_DATA) id[0] = ~id[0];
        len = $urandom_range(0, 8);
        push_id(id);
        push_le(len, 4);
        repeat (len) wav_bytes.push_back(8'($urandom));
    endtask

    task build_file(input t_file_kind kind, input logic [15:0] chans,
                    input logic [15:0] sample_bits, input logic [31:0] data_size,
                    input int data_sent);
        logic [15:0] tag;
        logic [15:0] chans_v;
        logic [15:0] bits_v;
        logic [31:0] riff_len;
        logic [31:0] rate;
        int          extra;
        int          keep;
        wav_bytes.delete();
        if (kind == FILE_NOISE) begin
            repeat ($urandom_range(1, 24)) wav_bytes.push_back(8'($urandom));
            return;
        end
        if (kind == FILE_NO_RIFF) begin
            repeat ($urandom_range(1, 3)) push_junk_chunk();
            return;
        end
        repeat ($urandom_range(0, 1)) push_junk_chunk();
        push_id(ID_RIFF);
        case ($urandom_range(0, 3))
            0: riff_len = 32'hFFFF_FFFF;
            1: riff_len = 32'd1;
            default: riff_len = $urandom_range(36, 4000);
        endcase
        if (kind == FILE_RIFF_EMPTY) riff_len = '0;
        push_le(riff_len, 4);
        if (kind == FILE_RIFF_EMPTY) begin
            repeat ($urandom_range(0, 4)) wav_bytes.push_back(8'($urandom));
            return;
        end
        push_id(kind == FILE_NOT_WAVE ? ID_WAVE ^ (32'd1 << $urandom_range(0, 31)) : ID_WAVE);
        if (kind == FILE_NOT_WAVE) return;
        repeat ($urandom_range(0, 2)) push_junk_chunk();
        push_id(ID_FMT);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        push_le(kind == FILE_FMT_SHORT ? $urandom_range(0, 15) : 16 + extra, 4);
        if (kind == FILE_FMT_SHORT) return;
        tag     = 16'd1;
        chans_v = chans;
        bits_v  = sample_bits;
        case ($urandom_range(0, 3))
            0: rate = '0;
            1: rate = 32'hFFFF_FFFF;
            default: rate = $urandom;
        endcase
        if (kind == FILE_NOT_PCM) begin
            case ($urandom_range(0, 3))
                0: tag = 16'h0000;
                1: tag = 16'h0003;
                2: tag = 16'hFFFE;
                default: tag = 16'h0101;
            endcase
        end
        if (kind == FILE_BAD_CHAN) begin
            case ($urandom_range(0, 3))
                0: chans_v = 16'h0000;
                1: chans_v = 16'h0003;
                2: chans_v = 16'h0101;
                default: chans_v = 16'hFFFF;
            endcase
        end
        if (kind == FILE_BAD_BITS) begin
            case ($urandom_range(0, 4))
                0: bits_v = 16'h0000;
                1: bits_v = 16'h000C;
                2: bits_v = 16'h0018;
                3: bits_v = 16'h0108;
                default: bits_v = 16'h1000;
            endcase
        end
        push_le(tag, 2);
        push_le(chans_v, 2);
        push_le(rate, 4);
        push_le($urandom, 4);
        push_le($urandom, 2);
        push_le(bits_v, 2);
        if (kind == FILE_NOT_PCM || kind == FILE_BAD_CHAN || kind == FILE_BAD_BITS) return;
        repeat (extra) wav_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 2)) push_junk_chunk();
        push_id(ID_DATA);
        push_le(kind == FILE_DATA_EMPTY ? 32'd0 : data_size, 4);
        if (kind == FILE_DATA_EMPTY) return;
        repeat (data_sent) wav_bytes.push_back(pick_byte());
        if (kind == FILE_TRUNCATED) begin
            keep = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > keep) void'(wav_bytes.pop_back());
        end
    endtask

    task send_directed(input t_file_kind kind, input logic [15:0] chans,
                       input logic [15:0] sample_bits, input logic [31:0] data_size,
                       input int data_sent);
        build_file(kind, chans, sample_bits, data_size, data_sent);
        send_file(1'b1, 1'b1, kind == FILE_NOISE);
    endtask

    initial begin : stimulus
        int          file_no;
        int          r;
        int          data_sent;
        logic [31:0] data_size;
        logic        stereo_sel;
        t_file_kind  kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files: each format, the early ends, and every rejection.
        write_output_mode(1'b1);
        send_directed(FILE_GOOD, 16'd2, 16'd16, 32'd8, 8);
        send_directed(FILE_GOOD, 16'd1, 16'd8, 32'd4, 4);
        send_directed(FILE_GOOD, 16'd1, 16'd16, 32'd3, 3);
        send_directed(FILE_GOOD, 16'd2, 16'd8, 32'hFFFF_FFFF, 5);
        for (int k = FILE_NO_RIFF; k <= FILE_NOISE; k++) begin
            send_directed(t_file_kind'(k), 16'd2, 16'd16, 32'd6, 6);
        end
        write_output_mode(1'b0);
        send_directed(FILE_GOOD, 16'd2, 16'd16, 32'd12, 12);
        send_directed(FILE_GOOD, 16'd2, 16'd8, 32'd6, 6);
        send_directed(FILE_GOOD, 16'd1, 16'd8, 32'd4, 4);

        file_no    = 0;
        stereo_sel = 1'b0;
        while (bytes_sent < ITEM_TARGET) begin
            if (file_no % 8 == 7) begin
                stereo_sel = ~stereo_sel;
                write_output_mode(stereo_sel);
            end
            if (file_no == 4) begin
                // Hold the result side off while one file streams in at full rate.
                drain_results();
                hold_requests++;
                wait (holds_started == hold_requests);
                full_rate = 1'b1;
                build_file(FILE_GOOD, 16'd1, 16'd8, 32'd80, 80);
                send_file(1'b1, 1'b1, 1'b0);
            end
            full_rate = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 62) kind = FILE_GOOD;
            else if (r < 72) kind = FILE_TRUNCATED;
            else if (r < 76) kind = FILE_NOISE;
            else kind = t_file_kind'($urandom_range(FILE_NO_RIFF, FILE_DATA_EMPTY));
            r = $urandom_range(0, 9);
            if (r == 0) begin
                data_size = 32'hFFFF_FFFF;
                data_sent = $urandom_range(1, 40);
            end else begin
                data_size = $urandom_range(1, 32);
                if (r == 1) data_sent = $urandom_range(1, data_size);
                else if (r == 2) data_sent = data_size + $urandom_range(1, 4);
                else data_sent = data_size;
            end
            build_file(kind, 16'($urandom_range(1, 2)), $urandom_range(0, 1) ? 16'd16 : 16'd8,
                       data_size, data_sent);
            send_file($urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0,
                      kind == FILE_NOISE);
            file_no++;
        end
        full_rate = 1'b0;

        drain_results();
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* wav_stream_pcm_decoder.f */
sv/wsp_pkg.sv
sv/wsp_front.sv
sv/wsp_queue.sv
sv/wsp_back.sv
sv/wav_stream_pcm_decoder.sv
dv/wav_stream_pcm_decoder_checker.sv
dv/wav_stream_pcm_decoder_tb.sv
